// ===== src/gdtf_pkg.sv =====
// ----------------------------------------------------------------------------
// gdtf_pkg
// Shared widths, row layout and control types for the graph distance term
// filter.
// ----------------------------------------------------------------------------
package gdtf_pkg;

   localparam int VERTEX_W  = 8;
   localparam int COEFF_W   = 32;
   localparam int CFG_W     = 4;
   localparam int SLOTS     = 4;
   localparam int NBR_SLOTS = SLOTS - 1;
   localparam int CNT_W     = 2;
   localparam int TERM_PORTS = 8;
   localparam int JDX_W     = 4;

   localparam int DEF_VERTEX_COUNT = 128;
   localparam int DEF_MAX_TERM_DIM = 8;

   localparam logic [CFG_W-1:0] TERM_DIM_RESET = CFG_W'(8);
   localparam logic [CNT_W-1:0] CNT_FULL       = CNT_W'(NBR_SLOTS);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   // One table row: neighbor count and up to three neighbors (self is implied)
   typedef struct packed {
      logic [CNT_W-1:0]                   cnt;
      logic [NBR_SLOTS-1:0][VERTEX_W-1:0] nbr;
   } row_type;

   // Control from the sequencer to the list matcher
   typedef struct packed {
      logic clear;
      logic load;
   } match_ctl_type;

endpackage

// ===== src/gdtf_table.sv =====
// ----------------------------------------------------------------------------
// gdtf_table
// Dual-port neighbor table, one row per vertex, with registered read data
// and a valid bit per row so an unwritten row reads as an empty list.
// ----------------------------------------------------------------------------
module gdtf_table
   import gdtf_pkg::*;
#(
   parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
   localparam int IDX_W = $clog2(VERTEX_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  row_type          wr_row,
   output row_type          rd_row
);

   row_type                 mem [VERTEX_COUNT];
   row_type                 rd_data_ff;
   logic                    rd_vld_ff;
   logic [VERTEX_COUNT-1:0] row_vld_ff;

   // Write and read the row storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Track which rows hold data
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   // Present an unwritten row as having no neighbors
   always_comb begin
      rd_row     = rd_data_ff;
      rd_row.cnt = rd_vld_ff ? rd_data_ff.cnt : '0;
   end

endmodule

// ===== src/gdtf_matcher.sv =====
// ----------------------------------------------------------------------------
// gdtf_matcher
// Holds the closed neighbor lists of the term vertices seen so far and
// compares each new list against all of them, accumulating the reject flag.
// ----------------------------------------------------------------------------
module gdtf_matcher
   import gdtf_pkg::*;
#(
   parameter int MAX_TERM_DIM = DEF_MAX_TERM_DIM
) (
   input  logic                clock,
   input  logic                reset,
   input  match_ctl_type       ctl,
   input  row_type             row,
   input  logic [VERTEX_W-1:0] self_vtx,
   output logic                rejected
);

   localparam int LW = $clog2(MAX_TERM_DIM);
   localparam int NW = $clog2(MAX_TERM_DIM + 1);

   logic [SLOTS-1:0][VERTEX_W-1:0] list_ff     [MAX_TERM_DIM];
   logic [SLOTS-1:0]               slot_vld_ff [MAX_TERM_DIM];
   logic [NW-1:0]                  num_ff;
   logic                           rej_ff;

   logic [SLOTS-1:0][VERTEX_W-1:0] new_list;
   logic [SLOTS-1:0]               new_vld;
   logic                           hit;
   logic                           store;

   // Build the closed list of the incoming vertex
   always_comb begin
      new_list[0] = self_vtx;
      new_vld[0]  = 1'b1;
      for (int s = 1; s < SLOTS; s++) begin
         new_list[s] = row.nbr[s-1];
         new_vld[s]  = CNT_W'(s - 1) < row.cnt;
      end
   end

   // Compare the new list with every stored list
   always_comb begin
      hit = 1'b0;
      for (int l = 0; l < MAX_TERM_DIM; l++) begin
         for (int i = 0; i < SLOTS; i++) begin
            for (int k = 0; k < SLOTS; k++) begin
               if (slot_vld_ff[l][i] && new_vld[k] && list_ff[l][i] == new_list[k]) begin
                  hit = 1'b1;
               end
            end
         end
      end
   end

   assign store = ctl.load && (num_ff < NW'(MAX_TERM_DIM));

   // Store list payload
   always_ff @(posedge clock) begin
      if (store) begin
         list_ff[num_ff[LW-1:0]] <= new_list;
      end
   end

   // Advance list count, slot valids and reject flag
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int l = 0; l < MAX_TERM_DIM; l++) begin
            slot_vld_ff[l] <= '0;
         end
         num_ff <= '0;
         rej_ff <= 1'b0;
      end else if (ctl.load) begin
         rej_ff <= rej_ff | hit;
         if (store) begin
            slot_vld_ff[num_ff[LW-1:0]] <= new_vld;
            num_ff                      <= num_ff + NW'(1);
         end
      end
   end

   assign rejected = rej_ff;

endmodule

// ===== src/graph_distance_term_filter.sv =====
// Load-edge item: accepted, then S_EA_RD, S_EA_WR, S_EB_RD and S_EB_WR read and
// write each endpoint's row through the table's read and write ports; no result.
// Check-term item: accepted, then one table read per listed vertex, the last
// compare as S_TERM ends and the result posted from S_DONE once the output is
// free. The block takes no new item until the current one is finished.
// Reset (synchronous): term_dim returns to 8, every vertex list holds only itself.
// ----------------------------------------------------------------------------
// graph_distance_term_filter
// Neighbor-list table for a degree-three graph and a term filter that zeroes
// the coefficient of any term with two vertices within distance two.
// ----------------------------------------------------------------------------
module graph_distance_term_filter
   import gdtf_pkg::*;
#(
   parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
   parameter int MAX_TERM_DIM = DEF_MAX_TERM_DIM
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [COEFF_W-1:0]  req_coeff,
   input  logic [VERTEX_W-1:0] req_vertex_0,
   input  logic [VERTEX_W-1:0] req_vertex_1,
   input  logic [VERTEX_W-1:0] req_vertex_2,
   input  logic [VERTEX_W-1:0] req_vertex_3,
   input  logic [VERTEX_W-1:0] req_vertex_4,
   input  logic [VERTEX_W-1:0] req_vertex_5,
   input  logic [VERTEX_W-1:0] req_vertex_6,
   input  logic [VERTEX_W-1:0] req_vertex_7,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COEFF_W-1:0]  rsp_out_coeff,
   output logic                rsp_rejected,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_term_dim
);

   localparam int IDX_W = $clog2(VERTEX_COUNT);
   localparam int LUT_N = 1 << VERTEX_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EA_RD = 3'd1;
   localparam logic [2:0] S_EA_WR = 3'd2;
   localparam logic [2:0] S_EB_RD = 3'd3;
   localparam logic [2:0] S_EB_WR = 3'd4;
   localparam logic [2:0] S_TERM  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [JDX_W-1:0]    j_ff, j_in;
   logic                pend_ff, pend_in;
   logic [CFG_W-1:0]    term_dim_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COEFF_W-1:0]  out_coeff_ff;
   logic                out_rej_ff;
   logic                load_out;

   logic [COEFF_W-1:0]  coeff_ff;
   logic [VERTEX_W-1:0] vert_ff [TERM_PORTS];
   logic [IDX_W-1:0]    idx_a_ff, idx_a_in;
   logic [IDX_W-1:0]    idx_b_ff, idx_b_in;
   logic [IDX_W-1:0]    self_ff, self_in;

   logic [IDX_W-1:0]    mod_lut [LUT_N];
   logic [VERTEX_W-1:0] raw_vtx;
   logic [IDX_W-1:0]    raw_idx;
   logic [CFG_W-1:0]    dim;
   logic                accept;
   logic                issue;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   row_type             wr_row;
   row_type             rd_row;
   logic [VERTEX_W-1:0] append_vtx;

   match_ctl_type       mctl;
   logic                rejected;

   // Constant table for vertex number modulo the vertex count
   for (genvar g = 0; g < LUT_N; g++) begin : g_mod
      assign mod_lut[g] = IDX_W'(g % VERTEX_COUNT);
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign dim       = (term_dim_ff > CFG_W'(MAX_TERM_DIM)) ? CFG_W'(MAX_TERM_DIM)
                                                            : term_dim_ff;

   // Pick the vertex that goes through the modulo table this cycle
   always_comb begin
      case (state_ff)
         S_EA_RD: raw_vtx = vert_ff[0];
         S_EA_WR: raw_vtx = vert_ff[1];
         default: raw_vtx = vert_ff[j_ff[2:0]];
      endcase
   end
   assign raw_idx = mod_lut[raw_vtx];

   assign issue = (state_ff == S_TERM) && (j_ff < JDX_W'(dim)) && (raw_vtx != '0);

   // Append one neighbor to the row just read, unless the list is full
   always_comb begin
      append_vtx = (state_ff == S_EA_WR) ? VERTEX_W'(raw_idx) : VERTEX_W'(idx_a_ff);
      wr_row     = rd_row;
      if (rd_row.cnt < CNT_FULL) begin
         wr_row.nbr[rd_row.cnt] = append_vtx;
         wr_row.cnt             = rd_row.cnt + CNT_W'(1);
      end
   end

   // Table port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = raw_idx;
      wr_en   = 1'b0;
      wr_addr = idx_a_ff;
      case (state_ff)
         S_EA_RD: rd_en = 1'b1;
         S_EA_WR: wr_en = (rd_row.cnt < CNT_FULL);
         S_EB_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_b_ff;
         end
         S_EB_WR: begin
            wr_en   = (rd_row.cnt < CNT_FULL);
            wr_addr = idx_b_ff;
         end
         S_TERM:  rd_en = issue;
         default: rd_en = 1'b0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      pend_in      = 1'b0;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      self_in      = self_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mctl.clear   = 1'b0;
      mctl.load    = pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               j_in       = '0;
               mctl.clear = 1'b1;
               state_in   = (req_func == FUNC_CHECK) ? S_TERM : S_EA_RD;
            end
         end
         S_EA_RD: begin
            idx_a_in = raw_idx;
            state_in = S_EA_WR;
         end
         S_EA_WR: begin
            idx_b_in = raw_idx;
            state_in = S_EB_RD;
         end
         S_EB_RD: state_in = S_EB_WR;
         S_EB_WR: state_in = S_IDLE;
         S_TERM: begin
            if (issue) begin
               self_in = raw_idx;
               pend_in = 1'b1;
               j_in    = j_ff + JDX_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         term_dim_ff  <= TERM_DIM_RESET;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            term_dim_ff <= csr_term_dim;
         end
      end
   end

   // Hold the item payload and working indexes
   always_ff @(posedge clock) begin
      if (accept) begin
         coeff_ff   <= req_coeff;
         vert_ff[0] <= req_vertex_0;
         vert_ff[1] <= req_vertex_1;
         vert_ff[2] <= req_vertex_2;
         vert_ff[3] <= req_vertex_3;
         vert_ff[4] <= req_vertex_4;
         vert_ff[5] <= req_vertex_5;
         vert_ff[6] <= req_vertex_6;
         vert_ff[7] <= req_vertex_7;
      end
      idx_a_ff <= idx_a_in;
      idx_b_ff <= idx_b_in;
      self_ff  <= self_in;
      if (load_out) begin
         out_coeff_ff <= rejected ? '0 : coeff_ff;
         out_rej_ff   <= rejected;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_coeff = out_coeff_ff;
   assign rsp_rejected  = out_rej_ff;

   gdtf_table #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .rd_row  (rd_row)
   );

   gdtf_matcher #(
      .MAX_TERM_DIM (MAX_TERM_DIM)
   ) u_matcher (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mctl),
      .row      (rd_row),
      .self_vtx (VERTEX_W'(self_ff)),
      .rejected (rejected)
   );

endmodule
